@@ hdl/plgs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the divider step for the gray stretch block
// no dependencies

package plgs_pkg;

    // pixel format
    localparam int PIXEL_BITS = 8;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    // derived arithmetic widths
    localparam int DY_BITS   = PIXEL_BITS + 1;         // signed output step
    localparam int PA_BITS   = 2 * PIXEL_BITS + 2;     // signed dy * dx
    localparam int PB_BITS   = 2 * PIXEL_BITS;         // y0 * den
    localparam int NUM_BITS  = 2 * PIXEL_BITS + 1;     // 2*num terms, < 2*den*2^PIXEL_BITS
    localparam int SUM_BITS  = NUM_BITS + 3;           // signed sum before trimming
    localparam int DD_BITS   = PIXEL_BITS + 1;         // divisor 2*den

    // divider layout: quotient bits resolved per pipeline stage
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = PIXEL_BITS / BITS_PER_STAGE;
    localparam int LATENCY        = 3 + DIV_STAGES;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KNEE_IN_LOW   = 2'd0,
        REG_KNEE_IN_HIGH  = 2'd1,
        REG_KNEE_OUT_LOW  = 2'd2,
        REG_KNEE_OUT_HIGH = 2'd3
    } cfg_reg_t;

    // one divider stage: partial remainder, numerator bits that shift out
    // while quotient bits shift in, and the divisor
    typedef struct packed {
        logic [DD_BITS-1:0]    rem;
        logic [PIXEL_BITS-1:0] low;
        logic [DD_BITS-1:0]    dd;
    } div_t;

    // one restoring division step: one quotient bit
    function automatic div_t div_step(input div_t d);
        logic [DD_BITS:0] trial;
        div_t             r;
        trial = {d.rem, d.low[PIXEL_BITS-1]};
        r     = d;
        if (trial >= {1'b0, d.dd})
        begin
            trial = trial - {1'b0, d.dd};
            r.low = {d.low[PIXEL_BITS-2:0], 1'b1};
        end
        else
        begin
            r.low = {d.low[PIXEL_BITS-2:0], 1'b0};
        end
        r.rem = trial[DD_BITS-1:0];
        return r;
    endfunction

endpackage

@@ hdl/piecewise_linear_gray_stretch.sv @@
`timescale 1ns / 1ps
// Piecewise-linear gray-level contrast stretch, one pixel per clock.
//
// Usage:
//   - config: write knee registers through cfg_write / cfg_index / cfg_data
//     while no item is in flight; a write takes effect at once, no read-back
//   - input: an item (pixel_in) is taken at a rising edge with start high and
//     busy low; busy is always low, so a pixel may enter every cycle
//   - output: done is high for exactly one cycle with pixel_out valid; the
//     receiver must take it in that cycle, there is no backpressure
//   - throughput: one item per cycle
//   - pipeline: segment select, two multiplies, numerator sum, then a
//     restoring divider that resolves two quotient bits per stage over four
//     stages; those seven register stages set the latency
//   - reset: rst_n (async, active low) clears all valid bits and loads the
//     knees to (0,0) and (255,255), i.e. an identity curve
// Depends on plgs_pkg.

module piecewise_linear_gray_stretch (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_write,
    input  plgs_pkg::cfg_reg_t             cfg_index,
    input  logic [plgs_pkg::PIXEL_BITS-1:0] cfg_data,
    // input items
    input  logic                           start,
    output logic                           busy,
    input  logic [plgs_pkg::PIXEL_BITS-1:0] pixel_in,
    // result items
    output logic                           done,
    output logic [plgs_pkg::PIXEL_BITS-1:0] pixel_out
);

    import plgs_pkg::*;

    // knee registers
    logic [PIXEL_BITS-1:0] knee_in_low_reg;
    logic [PIXEL_BITS-1:0] knee_in_high_reg;
    logic [PIXEL_BITS-1:0] knee_out_low_reg;
    logic [PIXEL_BITS-1:0] knee_out_high_reg;

    // stage 1: segment parameters
    logic                         s1_valid_reg;
    logic [PIXEL_BITS-1:0]        s1_y0_reg;
    logic signed [DY_BITS-1:0]    s1_dy_reg;
    logic [PIXEL_BITS-1:0]        s1_dx_reg;
    logic [PIXEL_BITS-1:0]        s1_den_reg;
    logic [PIXEL_BITS-1:0]        s1_y0_next;
    logic signed [DY_BITS-1:0]    s1_dy_next;
    logic [PIXEL_BITS-1:0]        s1_dx_next;
    logic [PIXEL_BITS-1:0]        s1_den_next;

    // stage 2: products
    logic                         s2_valid_reg;
    logic signed [PA_BITS-1:0]    s2_pa_reg;
    logic [PB_BITS-1:0]           s2_pb_reg;
    logic [PIXEL_BITS-1:0]        s2_den_reg;

    // stage 3: numerator, divider entry
    logic                         s3_valid_reg;
    div_t                         s3_div_reg;
    logic signed [SUM_BITS-1:0]   s3_sum_next;
    div_t                         s3_div_next;

    // divider stages
    logic [DIV_STAGES-1:0]        dv_valid_reg;
    div_t                         dv_reg  [DIV_STAGES];
    div_t                         dv_next [DIV_STAGES];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knee_in_low_reg   <= '0;
            knee_in_high_reg  <= PIX_MAX;
            knee_out_low_reg  <= '0;
            knee_out_high_reg <= PIX_MAX;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KNEE_IN_LOW:   knee_in_low_reg   <= cfg_data;
                REG_KNEE_IN_HIGH:  knee_in_high_reg  <= cfg_data;
                REG_KNEE_OUT_LOW:  knee_out_low_reg  <= cfg_data;
                REG_KNEE_OUT_HIGH: knee_out_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // segment select; later segments win, equal knees give knee_out_high
    always_comb
    begin
        if (pixel_in > knee_in_high_reg)
        begin
            s1_y0_next  = knee_out_high_reg;
            s1_dy_next  = $signed({1'b0, PIX_MAX}) - $signed({1'b0, knee_out_high_reg});
            s1_dx_next  = pixel_in - knee_in_high_reg;
            s1_den_next = PIX_MAX - knee_in_high_reg;
        end
        else if (pixel_in >= knee_in_low_reg)
        begin
            if (knee_in_high_reg == knee_in_low_reg)
            begin
                // flat point: (2*y0 + 1) / 2 rounds down to y0
                s1_y0_next  = knee_out_high_reg;
                s1_dy_next  = '0;
                s1_dx_next  = '0;
                s1_den_next = PIXEL_BITS'(1);
            end
            else
            begin
                s1_y0_next  = knee_out_low_reg;
                s1_dy_next  = $signed({1'b0, knee_out_high_reg})
                            - $signed({1'b0, knee_out_low_reg});
                s1_dx_next  = pixel_in - knee_in_low_reg;
                s1_den_next = knee_in_high_reg - knee_in_low_reg;
            end
        end
        else
        begin
            s1_y0_next  = '0;
            s1_dy_next  = $signed({1'b0, knee_out_low_reg});
            s1_dx_next  = pixel_in;
            s1_den_next = knee_in_low_reg;
        end
    end

    // numerator 2*dy*dx + 2*y0*den + den and divisor 2*den
    always_comb
    begin
        s3_sum_next = (SUM_BITS'(s2_pa_reg) <<< 1)
                    + SUM_BITS'($signed({1'b0, s2_pb_reg, 1'b0}))
                    + SUM_BITS'($signed({1'b0, s2_den_reg}));
        s3_div_next.rem = s3_sum_next[NUM_BITS-1:PIXEL_BITS];
        s3_div_next.low = s3_sum_next[PIXEL_BITS-1:0];
        s3_div_next.dd  = {s2_den_reg, 1'b0};
    end

    // divider stages, BITS_PER_STAGE quotient bits each
    always_comb
    begin
        dv_next[0] = s3_div_reg;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            dv_next[s] = dv_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int b = 0; b < BITS_PER_STAGE; b++)
            begin
                dv_next[s] = div_step(dv_next[s]);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            dv_valid_reg <= {dv_valid_reg[DIV_STAGES-2:0], s3_valid_reg};
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        s1_y0_reg  <= s1_y0_next;
        s1_dy_reg  <= s1_dy_next;
        s1_dx_reg  <= s1_dx_next;
        s1_den_reg <= s1_den_next;

        // operands widened to the product width before the multiply
        s2_pa_reg  <= PA_BITS'(s1_dy_reg) * PA_BITS'($signed({1'b0, s1_dx_reg}));
        s2_pb_reg  <= s1_y0_reg * s1_den_reg;
        s2_den_reg <= s1_den_reg;

        s3_div_reg <= s3_div_next;

        for (int s = 0; s < DIV_STAGES; s++)
        begin
            dv_reg[s] <= dv_next[s];
        end
    end

    assign done      = dv_valid_reg[DIV_STAGES-1];
    assign pixel_out = dv_reg[DIV_STAGES-1].low;

    // every accepted item leaves the pipeline with done high after all register stages
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("item did not complete after pipeline latency");

    // segment chosen never divides by zero
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_den_reg != '0))
        else $error("zero segment width in pipeline");

    // quotient fits the pixel range: upper numerator part below divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_div_reg.rem < s3_div_reg.dd))
        else $error("quotient overflow at divider entry");

    // partial remainder is below the divisor at the divider output
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dv_reg[DIV_STAGES-1].rem < dv_reg[DIV_STAGES-1].dd))
        else $error("divider remainder out of range");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the piecewise-linear gray stretch block
// depends on plgs_pkg and piecewise_linear_gray_stretch

module testbench;
    import plgs_pkg::*;

    localparam int PIX_TOP          = (1 << PIXEL_BITS) - 1;
    localparam int MAX_GAP          = 17;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PIXELS_PER_PHASE = 50;

    // expected pixel store plus a curve predictor with its own knee copy
    class gray_stretch_scoreboard;
        int knee_in_lo;
        int knee_in_hi;
        int knee_out_lo;
        int knee_out_hi;
        logic [PIXEL_BITS-1:0] expected_pixels[$];
        int errors;

        function new();
            knee_in_lo  = 0;
            knee_in_hi  = PIX_TOP;
            knee_out_lo = 0;
            knee_out_hi = PIX_TOP;
            errors      = 0;
        endfunction

        function void set_knee(cfg_reg_t idx, logic [PIXEL_BITS-1:0] value);
            case (idx)
                REG_KNEE_IN_LOW:   knee_in_lo  = value;
                REG_KNEE_IN_HIGH:  knee_in_hi  = value;
                REG_KNEE_OUT_LOW:  knee_out_lo = value;
                REG_KNEE_OUT_HIGH: knee_out_hi = value;
                default:           ;
            endcase
        endfunction

        // y0 + (y1 - y0) * dx / den, rounded half up, kept in pixel range
        function int segment(int y0, int y1, int dx, int den);
            int num;
            if (den <= 0)
                return y1;
            num = 2 * (y1 - y0) * dx + 2 * y0 * den + den;
            if (num < 0)
                num = 0;
            num = num / (2 * den);
            return (num > PIX_TOP) ? PIX_TOP : num;
        endfunction

        // later segment test wins when knees are out of order
        function logic [PIXEL_BITS-1:0] stretch(logic [PIXEL_BITS-1:0] pix);
            int p;
            int level;
            p     = pix;
            level = 0;
            if (p < knee_in_lo)
                level = segment(0, knee_out_lo, p, knee_in_lo);
            if (p >= knee_in_lo && p <= knee_in_hi)
            begin
                // equal input knees: pixel on the knee takes the high output knee
                if (knee_in_lo == knee_in_hi)
                    level = knee_out_hi;
                else
                    level = segment(knee_out_lo, knee_out_hi, p - knee_in_lo,
                                    knee_in_hi - knee_in_lo);
            end
            if (p > knee_in_hi)
                level = segment(knee_out_hi, PIX_TOP, p - knee_in_hi, PIX_TOP - knee_in_hi);
            return level[PIXEL_BITS-1:0];
        endfunction

        function void note_pixel(logic [PIXEL_BITS-1:0] pix);
            expected_pixels.push_back(stretch(pix));
        endfunction

        function void check_pixel(logic [PIXEL_BITS-1:0] actual);
            logic [PIXEL_BITS-1:0] want;
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_out: no item pending, actual %0d", actual);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (actual !== want)
                begin
                    $error("pixel_out: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    cfg_reg_t              cfg_index = REG_KNEE_IN_LOW;
    logic [PIXEL_BITS-1:0] cfg_data  = '0;
    logic                  start     = 1'b0;
    logic [PIXEL_BITS-1:0] pixel_in  = '0;
    logic                  busy;
    logic                  done;
    logic [PIXEL_BITS-1:0] pixel_out;
    int                    idle_cycles = 0;

    gray_stretch_scoreboard sb;

    piecewise_linear_gray_stretch u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result check, sampled at the edge that takes the item
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_pixel(pixel_out);
    end

    // watchdog on cycles without any accepted item, result or write
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // called in the step of the previous acceptance; start is left high on return
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        pixel_in <= pix;
        do
            @(posedge clk);
        while (busy);
        sb.note_pixel(pix);
    endtask

    // drop start and wait until every expected pixel has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // reprogram all four knees while the pipeline is empty
    task automatic set_knees(input int in_lo, input int in_hi, input int out_lo,
                             input int out_hi);
        cfg_reg_t              idx[4];
        logic [PIXEL_BITS-1:0] vals[4];
        idx  = '{REG_KNEE_IN_LOW, REG_KNEE_IN_HIGH, REG_KNEE_OUT_LOW, REG_KNEE_OUT_HIGH};
        vals = '{in_lo[PIXEL_BITS-1:0], in_hi[PIXEL_BITS-1:0],
                 out_lo[PIXEL_BITS-1:0], out_hi[PIXEL_BITS-1:0]};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_knee(idx[i], vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    // knee level biased toward the range ends
    function automatic int pick_knee();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return PIX_TOP;
            default: return $urandom_range(0, PIX_TOP);
        endcase
    endfunction

    // pixel biased toward the knees, otherwise uniform
    function automatic logic [PIXEL_BITS-1:0] pick_pixel(int in_lo, int in_hi);
        int v;
        case ($urandom_range(0, 3))
            0:       v = in_lo + $urandom_range(0, 4) - 2;
            1:       v = in_hi + $urandom_range(0, 4) - 2;
            default: v = $urandom_range(0, PIX_TOP);
        endcase
        if (v < 0)
            v = 0;
        if (v > PIX_TOP)
            v = PIX_TOP;
        return v[PIXEL_BITS-1:0];
    endfunction

    initial
    begin
        int  k_in_lo;
        int  k_in_hi;
        int  k_out_lo;
        int  k_out_hi;
        bit  burst;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity curve out of reset
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b1);
        send_pixel(8'd1, 1'b0);

        // equal input knees in the middle
        set_knees(100, 100, 30, 200);
        send_pixel(8'd99, 1'b1);
        send_pixel(8'd100, 1'b1);
        send_pixel(8'd101, 1'b0);

        // knees out of order: middle segment never taken
        set_knees(200, 50, 20, 230);
        send_pixel(8'd49, 1'b0);
        send_pixel(8'd50, 1'b1);
        send_pixel(8'd51, 1'b1);
        send_pixel(8'd199, 1'b0);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd201, 1'b0);

        // both input knees at zero, falling output knees
        set_knees(0, 0, 255, 0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b1);
        send_pixel(8'd255, 1'b0);

        // both knees at full scale
        set_knees(255, 255, 0, 255);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);

        // falling middle segment
        set_knees(64, 192, 255, 0);
        send_pixel(8'd63, 1'b1);
        send_pixel(8'd64, 1'b1);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd192, 1'b1);
        send_pixel(8'd193, 1'b0);

        // random curves with random pixels
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            k_in_lo  = pick_knee();
            k_in_hi  = ($urandom_range(0, 4) == 0) ? k_in_lo : pick_knee();
            k_out_lo = pick_knee();
            k_out_hi = pick_knee();
            set_knees(k_in_lo, k_in_hi, k_out_lo, k_out_hi);
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(pick_pixel(k_in_lo, k_in_hi), burst || ($urandom_range(0, 2) == 0));
        end

        drain();
        repeat (LATENCY + 2) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hdl/plgs_pkg.sv
hdl/piecewise_linear_gray_stretch.sv
tb/testbench.sv
